// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the top level of the projection block.
// Depends on nothing; SYNTH selects empty bodies for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define WPP_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WPP_ASSERT_NEVER(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);
`else
`define WPP_ASSERT(name, clk, rst, prop, msg)
`define WPP_ASSERT_NEVER(name, clk, rst, prop, msg)
`endif
`endif

// ===== rtl/core/wpp_pkg.sv =====
// Types, constants and helper functions of the projection block.
// Used by every module under rtl/core.
`default_nettype none
package wpp_pkg;
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int POSE_N      = 12;
   localparam int DIV_BITS    = 34;
   localparam int DIV_LAT     = DIV_BITS + 3;
   localparam int XFORM_LAT   = 3;
   localparam int TOTAL_LAT   = XFORM_LAT + DIV_LAT;

   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_PROJECT = 1'b1;

   localparam logic [1:0] REG_FOCAL_X  = 2'd0;
   localparam logic [1:0] REG_FOCAL_Y  = 2'd1;
   localparam logic [1:0] REG_CENTER_X = 2'd2;
   localparam logic [1:0] REG_CENTER_Y = 2'd3;

   localparam logic [31:0] ONE_FX = 32'(1) << FRAC_BITS;

   typedef struct packed {
      logic               func;
      logic [3:0]         pose_slot;
      logic signed [31:0] pose_value;
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] pixel_u;
      logic signed [31:0] pixel_v;
      logic signed [31:0] cam_depth;
      logic               zero_depth;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] focal_x;
      logic [31:0] focal_y;
      logic [31:0] center_x;
      logic [31:0] center_y;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } cam_point_type;

   function automatic logic signed [31:0] sat_cw(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh7FFF_FFFF;
      lo = -hi - 64'sd1;
      if (v > hi) return hi[31:0];
      if (v < lo) return lo[31:0];
      return v[31:0];
   endfunction
endpackage
`default_nettype wire

// ===== rtl/core/wpp_csr.sv =====
// Intrinsics register file behind the APB-style port.
// Depends on wpp_pkg.
`default_nettype none
module wpp_csr import wpp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output cfg_type          cfg
);
   cfg_type cfg_ff;
   logic    wr;

   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal_x  <= 32'd32768000;
         cfg_ff.focal_y  <= 32'd32768000;
         cfg_ff.center_x <= 32'd20971520;
         cfg_ff.center_y <= 32'd15728640;
      end else if (wr) begin
         unique case (paddr[3:2])
            REG_FOCAL_X:  cfg_ff.focal_x  <= pwdata;
            REG_FOCAL_Y:  cfg_ff.focal_y  <= pwdata;
            REG_CENTER_X: cfg_ff.center_x <= pwdata;
            REG_CENTER_Y: cfg_ff.center_y <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_FOCAL_X:  prdata = cfg_ff.focal_x;
         REG_FOCAL_Y:  prdata = cfg_ff.focal_y;
         REG_CENTER_X: prdata = cfg_ff.center_x;
         REG_CENTER_Y: prdata = cfg_ff.center_y;
         default:      prdata = '0;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/core/wpp_xform.sv =====
// Pose store and three-stage world-to-camera transform.
// Depends on wpp_pkg.
`default_nettype none
module wpp_xform import wpp_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  req_item_type      item,
   output cam_point_type     point
);
   logic signed [31:0] pose_ff [POSE_N];
   logic signed [63:0] prod_ff [9];
   logic signed [63:0] prod_in [9];
   logic signed [31:0] trans_ff [3];
   logic signed [49:0] sum_ff [3];
   logic signed [49:0] sum_in [3];
   logic               v1_ff, v2_ff;
   cam_point_type      pt_ff;
   logic signed [31:0] w [3];

   assign w[0] = item.world_x;
   assign w[1] = item.world_y;
   assign w[2] = item.world_z;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[r*3+k] = pose_ff[r*4+k] * w[k];
         end
      end
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = 50'(trans_ff[r]) + 50'(prod_ff[r*3] >>> FRAC_BITS)
                   + 50'(prod_ff[r*3+1] >>> FRAC_BITS) + 50'(prod_ff[r*3+2] >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POSE_N; i++) begin
            pose_ff[i] <= (i == 0 || i == 5 || i == 10) ? ONE_FX : 32'sd0;
         end
      end else if (accept && item.func == FUNC_LOAD && item.pose_slot < 4'(POSE_N)) begin
         pose_ff[item.pose_slot] <= item.pose_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         pt_ff.valid <= 1'b0;
      end else begin
         v1_ff       <= accept && item.func == FUNC_PROJECT;
         v2_ff       <= v1_ff;
         pt_ff.valid <= v2_ff;
      end
      for (int i = 0; i < 9; i++) prod_ff[i] <= prod_in[i];
      for (int r = 0; r < 3; r++) begin
         trans_ff[r] <= pose_ff[r*4+3];
         sum_ff[r]   <= sum_in[r];
      end
      pt_ff.x <= sat_cw(64'(sum_ff[0]));
      pt_ff.y <= sat_cw(64'(sum_ff[1]));
      pt_ff.z <= sat_cw(64'(sum_ff[2]));
   end

   assign point = pt_ff;
endmodule
`default_nettype wire

// ===== rtl/core/wpp_div.sv =====
// One pixel axis: focal product, pipelined restoring division, centre add.
// Depends on wpp_pkg.
`default_nettype none
module wpp_div import wpp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic [31:0]        focal,
   input  wire logic [31:0]        center,
   input  wire logic signed [31:0] num,
   input  wire logic signed [31:0] den,
   output logic                    out_valid,
   output logic signed [31:0]      pixel
);
   // stage A: focal product
   logic        va_ff;
   logic [63:0] prod_ff;
   logic [31:0] d_a_ff;
   logic        neg_a_ff, nneg_a_ff, dz_a_ff;
   logic [31:0] nmag, dmag;

   // division stages; stage 0 holds the overflow check and set-up
   logic                  vd_ff   [DIV_BITS+1];
   logic [32:0]           rem_ff  [DIV_BITS+1];
   logic [DIV_BITS-1:0]   low_ff  [DIV_BITS+1];
   logic [DIV_BITS-1:0]   q_ff    [DIV_BITS+1];
   logic [31:0]           d_ff    [DIV_BITS+1];
   logic                  neg_ff  [DIV_BITS+1];
   logic                  nneg_ff [DIV_BITS+1];
   logic                  dz_ff   [DIV_BITS+1];
   logic                  ovf_ff  [DIV_BITS+1];
   logic                  nz_ff   [DIV_BITS+1];
   logic [32:0]           trial   [DIV_BITS];

   logic                  vo_ff;
   logic signed [31:0]    pix_ff;
   logic [DIV_BITS-1:0]   qsel;
   logic signed [36:0]    sval;
   logic signed [31:0]    pix_in;

   assign nmag = num[31] ? 32'(-num) : 32'(num);
   assign dmag = den[31] ? 32'(-den) : 32'(den);

   always_comb begin
      for (int k = 0; k < DIV_BITS; k++) begin
         trial[k] = {rem_ff[k][31:0], low_ff[k][DIV_BITS-1]};
      end
      qsel = ovf_ff[DIV_BITS] ? '1 : q_ff[DIV_BITS];
      sval = neg_ff[DIV_BITS] ? -$signed({3'b000, qsel}) : $signed({3'b000, qsel});
      sval = sval + $signed({5'b00000, center});
      if (dz_ff[DIV_BITS]) begin
         if (!nz_ff[DIV_BITS]) pix_in = sat_cw(64'($signed({1'b0, center})));
         else if (nneg_ff[DIV_BITS]) pix_in = 32'sh8000_0000;
         else pix_in = 32'sh7FFF_FFFF;
      end else begin
         pix_in = sat_cw(64'(sval));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vo_ff <= 1'b0;
         for (int k = 0; k <= DIV_BITS; k++) vd_ff[k] <= 1'b0;
      end else begin
         va_ff    <= in_valid;
         vd_ff[0] <= va_ff;
         for (int k = 0; k < DIV_BITS; k++) vd_ff[k+1] <= vd_ff[k];
         vo_ff    <= vd_ff[DIV_BITS];
      end

      prod_ff   <= focal * nmag;
      d_a_ff    <= dmag;
      neg_a_ff  <= num[31] ^ den[31];
      nneg_a_ff <= num[31];
      dz_a_ff   <= den == 32'sd0;

      rem_ff[0]  <= 33'(prod_ff[63:DIV_BITS]);
      low_ff[0]  <= prod_ff[DIV_BITS-1:0];
      q_ff[0]    <= '0;
      d_ff[0]    <= d_a_ff;
      neg_ff[0]  <= neg_a_ff;
      nneg_ff[0] <= nneg_a_ff;
      dz_ff[0]   <= dz_a_ff;
      ovf_ff[0]  <= {2'b00, prod_ff[63:DIV_BITS]} >= d_a_ff;
      nz_ff[0]   <= prod_ff != 64'd0;

      for (int k = 0; k < DIV_BITS; k++) begin
         if (trial[k] >= {1'b0, d_ff[k]}) begin
            rem_ff[k+1] <= trial[k] - {1'b0, d_ff[k]};
            q_ff[k+1]   <= {q_ff[k][DIV_BITS-2:0], 1'b1};
         end else begin
            rem_ff[k+1] <= trial[k];
            q_ff[k+1]   <= {q_ff[k][DIV_BITS-2:0], 1'b0};
         end
         low_ff[k+1]  <= {low_ff[k][DIV_BITS-2:0], 1'b0};
         d_ff[k+1]    <= d_ff[k];
         neg_ff[k+1]  <= neg_ff[k];
         nneg_ff[k+1] <= nneg_ff[k];
         dz_ff[k+1]   <= dz_ff[k];
         ovf_ff[k+1]  <= ovf_ff[k];
         nz_ff[k+1]   <= nz_ff[k];
      end
      pix_ff <= pix_in;
   end

   assign out_valid = vo_ff;
   assign pixel     = pix_ff;
endmodule
`default_nettype wire

// ===== rtl/core/world_point_to_pixel_projection.sv =====
// Top level of the world point to pixel projection block.
// Depends on wpp_pkg, wpp_csr, wpp_xform, wpp_div and assert_macros.svh.
//
//   channel   ports                         handshake
//   request   start, busy, req_item         start && !busy
//   result    rsp_valid, rsp_item           one-cycle strobe
//   config    psel .. pready                psel && penable && pwrite
//
// One item per cycle; busy is always low. A project item's result passes
// through 3 transform stages, the focal multiply, the overflow check, 34
// division stages and the centre add. Load items give no result and take
// effect for items accepted from the next cycle on.
// Reset is synchronous and clears the pose to identity and all valid bits.
`default_nettype none
`include "assert_macros.svh"
module world_point_to_pixel_projection import wpp_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  req_item_type      req_item,
   output logic              rsp_valid,
   output rsp_item_type      rsp_item,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [3:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   cfg_type            cfg;
   cam_point_type      point;
   logic               u_valid, v_valid;
   logic signed [31:0] pix_u, pix_v;
   logic signed [31:0] depth_ff [DIV_LAT];
   logic               accept;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   wpp_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
   );

   wpp_xform u_xform (
      .clock(clock), .reset(reset), .accept(accept), .item(req_item), .point(point)
   );

   wpp_div u_div_u (
      .clock(clock), .reset(reset), .in_valid(point.valid), .focal(cfg.focal_x),
      .center(cfg.center_x), .num(point.x), .den(point.z),
      .out_valid(u_valid), .pixel(pix_u)
   );

   wpp_div u_div_v (
      .clock(clock), .reset(reset), .in_valid(point.valid), .focal(cfg.focal_y),
      .center(cfg.center_y), .num(point.y), .den(point.z),
      .out_valid(v_valid), .pixel(pix_v)
   );

   always_ff @(posedge clock) begin
      depth_ff[0] <= point.z;
      for (int k = 1; k < DIV_LAT; k++) depth_ff[k] <= depth_ff[k-1];
   end

   assign rsp_valid           = u_valid;
   assign rsp_item.pixel_u    = pix_u;
   assign rsp_item.pixel_v    = pix_v;
   assign rsp_item.cam_depth  = depth_ff[DIV_LAT-1];
   assign rsp_item.zero_depth = depth_ff[DIV_LAT-1] == 32'sd0;

   `WPP_ASSERT(a_axes_aligned, clock, reset, u_valid == v_valid, "axis pipelines out of step")
   `WPP_ASSERT(a_project_result, clock, reset, start && req_item.func == FUNC_PROJECT |-> ##TOTAL_LAT rsp_valid, "project item lost")
   `WPP_ASSERT(a_load_silent, clock, reset, start && req_item.func == FUNC_LOAD |-> ##TOTAL_LAT !rsp_valid, "load item gave a result")
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for world_point_to_pixel_projection.
// Depends on wpp_pkg; predicts each projection in fixed point and compares
// results as they stream out, across several intrinsic settings.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import wpp_pkg::*;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [3:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   world_point_to_pixel_projection uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready)
   );

   req_item_type       pending_items[$];
   rsp_item_type       expected_pixels[$];
   logic signed [31:0] pose_copy[POSE_N];
   logic [31:0]        fx_copy, fy_copy, cx_copy, cy_copy;
   int                 sender_idle_pct;
   int                 mismatches;
   int                 failures;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] pinhole_axis(input logic [31:0] f,
         input logic signed [31:0] num, input logic signed [31:0] den,
         input logic [31:0] c);
      logic [63:0]        mag;
      logic [63:0]        prod;
      logic [63:0]        d;
      logic [63:0]        q;
      logic signed [63:0] val;
      mag = num < 0 ? 64'(-64'(num)) : 64'(num);
      prod = {32'd0, f} * mag;
      if (den == 0) begin
         if (prod == 0) return clamp32($signed({32'd0, c}));
         return num < 0 ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      d = den < 0 ? 64'(-64'(den)) : 64'(den);
      q = prod / d;
      if (q > (64'd1 << 62)) q = 64'd1 << 62;
      val = ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
      val = val + $signed({32'd0, c});
      return clamp32(val);
   endfunction

   task automatic apply_item(input req_item_type it);
      logic signed [63:0] acc;
      logic signed [31:0] pw[3];
      logic signed [31:0] pc[3];
      rsp_item_type       r;
      if (it.func == FUNC_LOAD) begin
         if (it.pose_slot < POSE_N) pose_copy[it.pose_slot] = it.pose_value;
         return;
      end
      pw[0] = it.world_x;
      pw[1] = it.world_y;
      pw[2] = it.world_z;
      for (int row = 0; row < 3; row++) begin
         acc = 64'(pose_copy[row * 4 + 3]);
         for (int k = 0; k < 3; k++)
            acc = acc + ((64'(pose_copy[row * 4 + k]) * 64'(pw[k])) >>> FRAC_BITS);
         pc[row] = clamp32(acc);
      end
      r.pixel_u    = pinhole_axis(fx_copy, pc[0], pc[2], cx_copy);
      r.pixel_v    = pinhole_axis(fy_copy, pc[1], pc[2], cy_copy);
      r.cam_depth  = pc[2];
      r.zero_depth = (pc[2] == 0);
      expected_pixels.push_back(r);
   endtask

   // driver: predict on acceptance, then offer the next item
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) apply_item(req_item);
         if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            start    <= 1'b1;
            req_item <= pending_items.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid) begin
         if (expected_pixels.size() == 0) begin
            failures++;
            if (mismatches < 10)
               $display("unexpected result u=%h v=%h z=%h zd=%b", rsp_item.pixel_u,
                        rsp_item.pixel_v, rsp_item.cam_depth, rsp_item.zero_depth);
            mismatches++;
         end else begin
            want = expected_pixels.pop_front();
            if (want !== rsp_item) begin
               failures++;
               if (mismatches < 10)
                  $display("mismatch exp u=%h v=%h z=%h zd=%b got u=%h v=%h z=%h zd=%b",
                           want.pixel_u, want.pixel_v, want.cam_depth, want.zero_depth,
                           rsp_item.pixel_u, rsp_item.pixel_v, rsp_item.cam_depth,
                           rsp_item.zero_depth);
               mismatches++;
            end
         end
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_FOCAL_X:  fx_copy = value;
         REG_FOCAL_Y:  fy_copy = value;
         REG_CENTER_X: cx_copy = value;
         default:      cy_copy = value;
      endcase
   endtask

   function automatic req_item_type make_load(input int slot, input logic [31:0] value);
      req_item_type it;
      it = '0;
      it.func       = FUNC_LOAD;
      it.pose_slot  = 4'(slot);
      it.pose_value = value;
      it.world_x    = $urandom;
      it.world_y    = $urandom;
      it.world_z    = $urandom;
      return it;
   endfunction

   function automatic req_item_type make_point(input logic [31:0] x, input logic [31:0] y,
                                               input logic [31:0] z);
      req_item_type it;
      it.func       = FUNC_PROJECT;
      it.pose_slot  = 4'($urandom);
      it.pose_value = $urandom;
      it.world_x    = x;
      it.world_y    = y;
      it.world_z    = z;
      return it;
   endfunction

   function automatic logic [31:0] near_value(input int span);
      return 32'($signed($urandom_range(2 * span)) - span);
   endfunction

   function automatic req_item_type random_item();
      int pick;
      int slot;
      pick = $urandom_range(99);
      if (pick < 25) begin
         slot = $urandom_range(11);
         if ((slot % 4) == 3) return make_load(slot, near_value(1 << 24));
         return make_load(slot, near_value(1 << 17));
      end
      if (pick < 28) return make_load($urandom_range(15), $urandom);
      if (pick < 33) return make_point(near_value(1 << 20), near_value(1 << 20), 32'd0);
      if (pick < 43) return make_point($urandom, $urandom, $urandom);
      return make_point(near_value(1 << 22), near_value(1 << 22),
                        32'($urandom_range(1 << 23)) + 32'h0001_0000);
   endfunction

   task automatic drain();
      while (pending_items.size() > 0 || start || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (TOTAL_LAT + 8) @(posedge clock);
   endtask

   initial begin
      logic [31:0] cfg[4];
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      sender_idle_pct = 16;
      mismatches  = 0;
      failures    = 0;
      for (int i = 0; i < POSE_N; i++) pose_copy[i] = '0;
      pose_copy[0]  = ONE_FX;
      pose_copy[5]  = ONE_FX;
      pose_copy[10] = ONE_FX;
      fx_copy = 32'd32768000;
      fy_copy = 32'd32768000;
      cx_copy = 32'd20971520;
      cy_copy = 32'd15728640;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 6; ph++) begin
         sender_idle_pct = (ph < 2) ? 16 : (ph < 4) ? 65 : 0;
         for (int r = 0; r < 4; r++) begin
            case (ph)
               0:       cfg[r] = (r < 2) ? 32'd32768000 : (r == 2) ? 32'd20971520
                                                                    : 32'd15728640;
               1:       cfg[r] = 32'd0;
               2:       cfg[r] = 32'hFFFF_FFFF;
               default: cfg[r] = $urandom;
            endcase
            csr_write(2'(r), cfg[r]);
         end
         if (ph == 0) begin
            pending_items.push_back(make_point(32'h0001_0000, 32'h0002_0000, 32'h0004_0000));
            pending_items.push_back(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd0));
            pending_items.push_back(make_point(32'h8000_0000, 32'h7FFF_FFFF, 32'd0));
            pending_items.push_back(make_point(32'd0, 32'd0, 32'd0));
            pending_items.push_back(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1));
            pending_items.push_back(make_point(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF));
            pending_items.push_back(make_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000));
            pending_items.push_back(make_load(12, 32'h1234_5678));
            pending_items.push_back(make_load(15, 32'hFFFF_FFFF));
            pending_items.push_back(make_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
            pending_items.push_back(make_load(0, 32'h7FFF_FFFF));
            pending_items.push_back(make_load(3, 32'h8000_0000));
            pending_items.push_back(make_load(11, 32'h7FFF_FFFF));
            pending_items.push_back(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
            pending_items.push_back(make_load(10, 32'h8000_0000));
            pending_items.push_back(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
            pending_items.push_back(make_load(0, ONE_FX));
            pending_items.push_back(make_load(3, 32'd0));
            pending_items.push_back(make_load(10, ONE_FX));
            pending_items.push_back(make_load(11, 32'hFFFF_0000));
            pending_items.push_back(make_point(32'd0, 32'd0, 32'h0001_0000));
            pending_items.push_back(make_load(11, 32'd0));
         end
         for (int n = 0; n < 305; n++) pending_items.push_back(random_item());
         drain();
      end

      if (failures == 0 && expected_pixels.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
